### src/ectd_pkg.sv
package ectd_pkg;

  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int TOD_W   = 17;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // seconds per day is 675 << 7
  localparam int DAY_SHIFT  = 7;
  localparam int DAY_ODD    = 675;
  localparam int DAY_RECIP  = 6362914;

  // seconds per hour is 225 << 4, per minute 15 << 2
  localparam int HOUR_ODD   = 225;
  localparam int HOUR_RECIP = 291;
  localparam int MIN_ODD    = 15;
  localparam int MIN_RECIP  = 4369;

  // day 0 of the count falls on a Thursday
  localparam int WDAY_BIAS  = 3;
  localparam int WDAY_DIV   = 7;
  localparam int WDAY_RECIP = 149796;

  // Julian day of the first day plus the calendar offset
  localparam int JDN_BASE    = 2472632;
  localparam int CYC400      = 146097;
  localparam int CYC400_RCP  = 29398;
  localparam int CYC4        = 1461;
  localparam int CYC4_RCP    = 11483;
  localparam int MSPAN       = 153;
  localparam int MSPAN_RCP   = 428;
  localparam int DIV5_RCP    = 205;
  localparam int YEAR_BIAS   = 4800;
  localparam int MONTH_WRAP  = 10;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } split_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/ectd_queue.sv
module ectd_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ectd_pkg::split_t   data_i,
  input  logic               pop_i,
  output ectd_pkg::split_t   data_o,
  output ectd_pkg::q_stat_t  stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ectd_pkg::split_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/ectd_front.sv
module ectd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ectd_pkg::SECS_W-1:0]   epoch_seconds_i,
  input  ectd_pkg::q_stat_t             q_stat_i,
  output logic                          busy_o,
  output logic                          push_o,
  output ectd_pkg::split_t              split_o
);

  logic        en;
  logic        s0_vld_q, s1_vld_q;
  logic [31:0] secs_q;
  logic [47:0] prod;
  logic [15:0] qest_q;
  logic [24:0] x_q;
  logic [6:0]  lo_q;
  logic [24:0] qm;
  logic [10:0] rem;
  logic [10:0] rem_c;

  assign en     = !q_stat_i.full;
  assign busy_o = q_stat_i.full;
  assign push_o = s1_vld_q && en;

  assign prod = 48'(secs_q[31:ectd_pkg::DAY_SHIFT]) * 48'(ectd_pkg::DAY_RECIP);

  // estimate is low by at most one: correct with a single compare
  assign qm  = 25'(qest_q) * 25'(ectd_pkg::DAY_ODD);
  assign rem = 11'(x_q - qm);

  always_comb begin
    split_o.days = qest_q;
    rem_c        = rem;
    if (rem >= 11'(ectd_pkg::DAY_ODD)) begin
      split_o.days = qest_q + 16'd1;
      rem_c        = rem - 11'(ectd_pkg::DAY_ODD);
    end
    split_o.tod = {rem_c[9:0], lo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= start_i;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (start_i) begin
        secs_q <= epoch_seconds_i;
      end
      qest_q <= prod[47:32];
      x_q    <= secs_q[31:ectd_pkg::DAY_SHIFT];
      lo_q   <= secs_q[ectd_pkg::DAY_SHIFT-1:0];
    end
  end

endmodule

### src/ectd_back.sv
module ectd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  ectd_pkg::split_t               split_i,
  output logic                           valid_o,
  output logic [ectd_pkg::YEAR_W-1:0]    year_o,
  output logic [ectd_pkg::MONTH_W-1:0]   month_o,
  output logic [ectd_pkg::MDAY_W-1:0]    day_of_month_o,
  output logic [ectd_pkg::HOUR_W-1:0]    hour_o,
  output logic [ectd_pkg::MIN_W-1:0]     minute_o,
  output logic [ectd_pkg::SEC_W-1:0]     second_o,
  output logic [ectd_pkg::WDAY_W-1:0]    weekday_o
);

  logic [7:0] vld_q;

  // stage 0
  logic [15:0] days0_q;
  logic [16:0] tod0_q;
  // stage 1
  logic [23:0] n1_d, n1_q;
  logic [38:0] pb;
  logic [6:0]  qb1_q;
  logic [15:0] w1_d, w1_q;
  logic [33:0] pw;
  logic [13:0] qw1_q;
  logic [12:0] y1_q;
  logic [21:0] ph;
  logic [5:0]  qh1_q;
  logic [3:0]  tlo1_q;
  // stage 2
  logic [24:0] mb, r1, r1_c;
  logic [6:0]  b_d, b2_q;
  logic [15:0] c2_q;
  logic [15:0] mw;
  logic [3:0]  rw, rw_c;
  logic [2:0]  wd2_q;
  logic [12:0] mh;
  logic [8:0]  ry, ry_c;
  logic [5:0]  hr_d;
  logic [4:0]  hr2_q;
  logic [11:0] remh2_q;
  // stage 3
  logic [17:0] n2;
  logic [31:0] pd;
  logic [17:0] n2_q;
  logic [7:0]  qd3_q;
  logic [6:0]  b3_q;
  logic [2:0]  wd3_q;
  logic [4:0]  hr3_q;
  logic [9:0]  z;
  logic [21:0] pm;
  logic [9:0]  z3_q;
  logic [5:0]  qm3_q;
  logic [1:0]  slo3_q;
  // stage 4
  logic [17:0] md;
  logic [11:0] r2, r2_c;
  logic [7:0]  d_d;
  logic [8:0]  e;
  logic [10:0] n3_d, n4_q;
  logic [6:0]  d4_q, b4_q;
  logic [2:0]  wd4_q;
  logic [4:0]  hr4_q;
  logic [9:0]  mm;
  logic [4:0]  rz, rz_c;
  logic [5:0]  mi_d;
  logic [5:0]  mi4_q, se4_q;
  // stage 5
  logic [19:0] pmo;
  logic [10:0] n5_q;
  logic [3:0]  qmo5_q;
  logic [6:0]  d5_q, b5_q;
  logic [2:0]  wd5_q;
  logic [4:0]  hr5_q;
  logic [5:0]  mi5_q, se5_q;
  // stage 6
  logic [10:0] mmo;
  logic [8:0]  r3, r3_c;
  logic [3:0]  m_d, m6_q;
  logic [7:0]  r36_q;
  logic [6:0]  d6_q, b6_q;
  logic [2:0]  wd6_q;
  logic [4:0]  hr6_q;
  logic [5:0]  mi6_q, se6_q;
  // stage 7
  logic [15:0] p5;
  logic        wrap;
  logic [13:0] yr;

  // stage 1 arithmetic
  assign n1_d = {22'(24'(days0_q) + 24'(ectd_pkg::JDN_BASE)), 2'b11};
  assign pb   = 39'(n1_d) * 39'(ectd_pkg::CYC400_RCP);
  assign w1_d = days0_q + 16'(ectd_pkg::WDAY_BIAS);
  assign pw   = 34'(w1_d) * 34'(ectd_pkg::WDAY_RECIP);
  assign ph   = 22'(tod0_q[16:4]) * 22'(ectd_pkg::HOUR_RECIP);

  // stage 2 arithmetic
  assign mb = 25'(qb1_q) * 25'(ectd_pkg::CYC400);
  assign r1 = 25'(n1_q) - mb;
  assign mw = 16'(qw1_q) * 16'(ectd_pkg::WDAY_DIV);
  assign rw = 4'(w1_q - mw);
  assign mh = 13'(qh1_q) * 13'(ectd_pkg::HOUR_ODD);
  assign ry = 9'(y1_q - mh);

  always_comb begin
    b_d  = qb1_q;
    r1_c = r1;
    if (r1 >= 25'(ectd_pkg::CYC400)) begin
      b_d  = qb1_q + 7'd1;
      r1_c = r1 - 25'(ectd_pkg::CYC400);
    end
    rw_c = rw;
    if (rw >= 4'(ectd_pkg::WDAY_DIV)) begin
      rw_c = rw - 4'(ectd_pkg::WDAY_DIV);
    end
    hr_d = qh1_q;
    ry_c = ry;
    if (ry >= 9'(ectd_pkg::HOUR_ODD)) begin
      hr_d = qh1_q + 6'd1;
      ry_c = ry - 9'(ectd_pkg::HOUR_ODD);
    end
  end

  // stage 3 arithmetic
  assign n2 = {c2_q, 2'b11};
  assign pd = 32'(n2) * 32'(ectd_pkg::CYC4_RCP);
  assign z  = remh2_q[11:2];
  assign pm = 22'(z) * 22'(ectd_pkg::MIN_RECIP);

  // stage 4 arithmetic
  assign md = 18'(qd3_q) * 18'(ectd_pkg::CYC4);
  assign r2 = 12'(n2_q - md);
  assign mm = 10'(qm3_q) * 10'(ectd_pkg::MIN_ODD);
  assign rz = 5'(z3_q - mm);

  always_comb begin
    d_d  = qd3_q;
    r2_c = r2;
    if (r2 >= 12'(ectd_pkg::CYC4)) begin
      d_d  = qd3_q + 8'd1;
      r2_c = r2 - 12'(ectd_pkg::CYC4);
    end
    e    = r2_c[10:2];
    n3_d = {e, 2'b00} + 11'(e) + 11'd2;
    mi_d = qm3_q;
    rz_c = rz;
    if (rz >= 5'(ectd_pkg::MIN_ODD)) begin
      mi_d = qm3_q + 6'd1;
      rz_c = rz - 5'(ectd_pkg::MIN_ODD);
    end
  end

  // stage 5 arithmetic
  assign pmo = 20'(n4_q) * 20'(ectd_pkg::MSPAN_RCP);

  // stage 6 arithmetic
  assign mmo = 11'(qmo5_q) * 11'(ectd_pkg::MSPAN);
  assign r3  = 9'(n5_q - mmo);

  always_comb begin
    m_d  = qmo5_q;
    r3_c = r3;
    if (r3 >= 9'(ectd_pkg::MSPAN)) begin
      m_d  = qmo5_q + 4'd1;
      r3_c = r3 - 9'(ectd_pkg::MSPAN);
    end
  end

  // stage 7 arithmetic
  assign p5   = 16'(r36_q) * 16'(ectd_pkg::DIV5_RCP);
  assign wrap = (m6_q >= 4'(ectd_pkg::MONTH_WRAP));
  assign yr   = 14'(b6_q) * 14'd100 + 14'(d6_q) + 14'(wrap)
              - 14'(ectd_pkg::YEAR_BIAS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], vld_i};
    end
  end

  assign valid_o = vld_q[7];

  always_ff @(posedge clk_i) begin
    days0_q <= split_i.days;
    tod0_q  <= split_i.tod;

    n1_q   <= n1_d;
    qb1_q  <= pb[38:32];
    w1_q   <= w1_d;
    qw1_q  <= pw[33:20];
    y1_q   <= tod0_q[16:4];
    qh1_q  <= ph[21:16];
    tlo1_q <= tod0_q[3:0];

    b2_q    <= b_d;
    c2_q    <= r1_c[17:2];
    wd2_q   <= rw_c[2:0];
    hr2_q   <= hr_d[4:0];
    remh2_q <= {ry_c[7:0], tlo1_q};

    n2_q   <= n2;
    qd3_q  <= pd[31:24];
    b3_q   <= b2_q;
    wd3_q  <= wd2_q;
    hr3_q  <= hr2_q;
    z3_q   <= z;
    qm3_q  <= pm[21:16];
    slo3_q <= remh2_q[1:0];

    n4_q  <= n3_d;
    d4_q  <= d_d[6:0];
    b4_q  <= b3_q;
    wd4_q <= wd3_q;
    hr4_q <= hr3_q;
    mi4_q <= mi_d;
    se4_q <= {rz_c[3:0], slo3_q};

    n5_q   <= n4_q;
    qmo5_q <= pmo[19:16];
    d5_q   <= d4_q;
    b5_q   <= b4_q;
    wd5_q  <= wd4_q;
    hr5_q  <= hr4_q;
    mi5_q  <= mi4_q;
    se5_q  <= se4_q;

    m6_q  <= m_d;
    r36_q <= r3_c[7:0];
    d6_q  <= d5_q;
    b6_q  <= b5_q;
    wd6_q <= wd5_q;
    hr6_q <= hr5_q;
    mi6_q <= mi5_q;
    se6_q <= se5_q;

    year_o         <= yr[11:0];
    month_o        <= wrap ? m6_q - 4'd9 : m6_q + 4'd3;
    day_of_month_o <= 5'(p5[15:10]) + 5'd1;
    hour_o         <= hr6_q;
    minute_o       <= mi6_q;
    second_o       <= se6_q;
    weekday_o      <= wd6_q;
  end

endmodule

### src/epoch_seconds_to_calendar_date.sv
// Channel   Handshake            Payload
// command   start_i / busy_o     epoch_seconds_i
// result    valid_o (strobe)     year_o month_o day_of_month_o hour_o minute_o second_o weekday_o
//
// One item per cycle sustained while busy_o is low.
// Results pass the front split (2 stages), the queue slot and the 8-stage date pipeline, whose
// divisions each use a constant multiply, all but the day of month with a single-step quotient correction.
// Reset clears the valid bits and the queue; the result strobe cannot be held off, so the
// back pipeline never stalls and busy_o rises only if the queue fills.
module epoch_seconds_to_calendar_date #(
  parameter int QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ectd_pkg::SECS_W-1:0]   epoch_seconds_i,
  output logic                          valid_o,
  output logic [ectd_pkg::YEAR_W-1:0]   year_o,
  output logic [ectd_pkg::MONTH_W-1:0]  month_o,
  output logic [ectd_pkg::MDAY_W-1:0]   day_of_month_o,
  output logic [ectd_pkg::HOUR_W-1:0]   hour_o,
  output logic [ectd_pkg::MIN_W-1:0]    minute_o,
  output logic [ectd_pkg::SEC_W-1:0]    second_o,
  output logic [ectd_pkg::WDAY_W-1:0]   weekday_o
);

  ectd_pkg::split_t  push_data;
  ectd_pkg::split_t  head_data;
  ectd_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign pop = !q_stat.empty;

  ectd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .epoch_seconds_i (epoch_seconds_i),
    .q_stat_i        (q_stat),
    .busy_o          (busy_o),
    .push_o          (push),
    .split_o         (push_data)
  );

  ectd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (head_data),
    .stat_o (q_stat)
  );

  ectd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (pop),
    .split_i        (head_data),
    .valid_o        (valid_o),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .weekday_o      (weekday_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("queue filled although the back end drains every cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59))
    else $error("time of day out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o != 5'd0 &&
                 weekday_o <= 3'd6))
    else $error("date field out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (year_o >= 12'd1970 && year_o <= 12'd2106))
    else $error("year out of range");
`endif

endmodule
